// File: design/ptlf_pkg.sv
// ptlf_pkg: shared constants, types and state encodings for the page table translator
// no dependencies
package ptlf_pkg;

    localparam int MAX_FRAMES_DEF = 16;
    localparam int ADDR_BITS_DEF  = 20;
    localparam int VA_W           = 20;
    localparam int PA_W           = 20;
    localparam int FN_W           = 4;
    localparam int PS_W           = 17;
    localparam int FC_W           = 5;
    localparam int CFG_W          = 17;
    localparam int IDX_W          = 2;

    localparam logic [IDX_W-1:0] REG_PAGE_SIZE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_COUNT = 2'd1;
    localparam logic [IDX_W-1:0] REG_POLICY      = 2'd2;

    localparam logic POLICY_LRU  = 1'b0;
    localparam logic POLICY_FIFO = 1'b1;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_READ,
        BK_SHIFT,
        BK_MUL,
        BK_OUT
    } back_state_t;

endpackage

// File: design/ptlf_front.sv
// ptlf_front: accepts virtual addresses and splits them into page and offset
// with a restoring divider, one quotient bit per cycle; depends on ptlf_pkg
module ptlf_front #(
    parameter int ADDR_BITS = ptlf_pkg::ADDR_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ptlf_pkg::VA_W-1:0]     virtual_address,
    input  logic [ptlf_pkg::PS_W-1:0]     page_words,
    output logic                          q_valid,
    input  logic                          q_ready,
    output logic [ADDR_BITS-1:0]          q_page,
    output logic [ADDR_BITS-1:0]          q_offset,
    output logic [ptlf_pkg::PS_W-1:0]     q_psize
);
    localparam int CNT_W = $clog2(ADDR_BITS + 1);
    localparam int REM_W = ptlf_pkg::PS_W + 1;

    ptlf_pkg::front_state_t state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [ADDR_BITS-1:0]      quo_reg, quo_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [ptlf_pkg::PS_W-1:0] div_reg, div_next;
    logic [REM_W-1:0]          trial;
    logic [REM_W-1:0]          shifted;
    logic [ADDR_BITS-1:0]      va_m;

    assign va_m = ADDR_BITS'(virtual_address);

    assign shifted = {rem_reg[REM_W-2:0], quo_reg[ADDR_BITS-1]};
    assign trial   = shifted - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptlf_pkg::FR_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        in_ready   = 1'b0;
        q_valid    = 1'b0;
        case (state_reg)
            ptlf_pkg::FR_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    quo_next   = va_m;
                    rem_next   = '0;
                    div_next   = (page_words == '0) ? ptlf_pkg::PS_W'(1) : page_words;
                    cnt_next   = CNT_W'(ADDR_BITS);
                    state_next = ptlf_pkg::FR_DIV;
                end
            end
            ptlf_pkg::FR_DIV:
            begin
                if (!trial[REM_W-1])
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[ADDR_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted;
                    quo_next = {quo_reg[ADDR_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    state_next = ptlf_pkg::FR_PUSH;
            end
            ptlf_pkg::FR_PUSH:
            begin
                q_valid = 1'b1;
                if (q_ready)
                    state_next = ptlf_pkg::FR_IDLE;
            end
            default:
                state_next = ptlf_pkg::FR_IDLE;
        endcase
    end

    assign q_page   = quo_reg;
    assign q_offset = ADDR_BITS'(rem_reg[REM_W-2:0]);
    assign q_psize  = div_reg;
endmodule

// File: design/ptlf_fifo.sv
// ptlf_fifo: two-entry word queue between front and back
// depends on ptlf_pkg only through its users' widths
module ptlf_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output logic [W-1:0] rd_data
);
    logic [W-1:0] mem_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic         do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= ~wp_reg;
            if (do_rd)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_data;
    end
endmodule

// File: design/ptlf_back.sv
// ptlf_back: ordered table scan, lru/fifo reorder and physical address build
// depends on ptlf_pkg
module ptlf_back #(
    parameter int MAX_FRAMES = ptlf_pkg::MAX_FRAMES_DEF,
    parameter int ADDR_BITS  = ptlf_pkg::ADDR_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic [ADDR_BITS-1:0]          q_page,
    input  logic [ADDR_BITS-1:0]          q_offset,
    input  logic [ptlf_pkg::PS_W-1:0]     q_psize,
    input  logic [ptlf_pkg::FC_W-1:0]     frame_count,
    input  logic                          policy,
    input  logic                          clear,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ptlf_pkg::PA_W-1:0]     physical_address,
    output logic [ptlf_pkg::FN_W-1:0]     frame_number,
    output logic                          page_fault
);
    localparam int IW = $clog2(MAX_FRAMES);
    localparam int NW = $clog2(MAX_FRAMES + 1);
    localparam int FW = IW;

    ptlf_pkg::back_state_t state_reg, state_next;

    logic [ADDR_BITS-1:0] pg_mem [MAX_FRAMES];
    logic [FW-1:0]        fr_mem [MAX_FRAMES];

    logic [NW-1:0]        occ_reg, occ_next;
    logic [NW-1:0]        n_reg, n_next;
    logic [NW-1:0]        idx_reg, idx_next;
    logic                 hit_reg, hit_next;
    logic [ADDR_BITS-1:0] page_reg, page_next;
    logic [ADDR_BITS-1:0] off_reg, off_next;
    logic [ptlf_pkg::PS_W-1:0] ps_reg, ps_next;
    logic [FW-1:0]        frame_reg, frame_next;
    logic [ADDR_BITS-1:0] mv_pg_reg, mv_pg_next;
    logic [ADDR_BITS+ptlf_pkg::PS_W-1:0] prod_reg, prod_next;
    logic [ptlf_pkg::PA_W-1:0] pa_trim;

    logic [ADDR_BITS-1:0] rd_pg_reg;
    logic [FW-1:0]        rd_fr_reg;
    logic [IW-1:0]        rd_addr;

    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [ADDR_BITS-1:0] wr_pg;
    logic [FW-1:0]        wr_fr;

    logic [NW-1:0]        fc_eff;
    logic [ADDR_BITS-1:0] pa_full;

    always_comb
    begin
        if (frame_count == '0)
            fc_eff = NW'(1);
        else if (32'(frame_count) > MAX_FRAMES)
            fc_eff = NW'(MAX_FRAMES);
        else
            fc_eff = NW'(frame_count);
    end

    always_ff @(posedge clk)
    begin
        rd_pg_reg <= pg_mem[rd_addr];
        rd_fr_reg <= fr_mem[rd_addr];
        if (wr_en)
        begin
            pg_mem[wr_addr] <= wr_pg;
            fr_mem[wr_addr] <= wr_fr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptlf_pkg::BK_IDLE;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= clear ? '0 : occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        idx_reg   <= idx_next;
        hit_reg   <= hit_next;
        page_reg  <= page_next;
        off_reg   <= off_next;
        ps_reg    <= ps_next;
        frame_reg <= frame_next;
        mv_pg_reg <= mv_pg_next;
        prod_reg  <= prod_next;
    end

    assign pa_full = prod_reg[ADDR_BITS-1:0] + off_reg;

    always_comb
    begin
        state_next = state_reg;
        occ_next   = occ_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        hit_next   = hit_reg;
        page_next  = page_reg;
        off_next   = off_reg;
        ps_next    = ps_reg;
        frame_next = frame_reg;
        mv_pg_next = mv_pg_reg;
        prod_next  = prod_reg;
        rd_addr    = idx_reg[IW-1:0];
        wr_en      = 1'b0;
        wr_addr    = idx_reg[IW-1:0];
        wr_pg      = page_reg;
        wr_fr      = frame_reg;
        q_ready    = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ptlf_pkg::BK_IDLE:
            begin
                q_ready = 1'b1;
                rd_addr = '0;
                if (q_valid)
                begin
                    page_next  = q_page;
                    off_next   = q_offset;
                    ps_next    = q_psize;
                    n_next     = (occ_reg > fc_eff) ? fc_eff : occ_reg;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    state_next = ptlf_pkg::BK_SCAN;
                end
            end
            // read data for idx_reg is valid this cycle
            ptlf_pkg::BK_SCAN:
            begin
                if (idx_reg == n_reg)
                begin
                    if (n_reg < fc_eff)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = idx_reg[IW-1:0];
                        wr_pg      = page_reg;
                        wr_fr      = idx_reg[FW-1:0];
                        frame_next = idx_reg[FW-1:0];
                        n_next     = n_reg + 1'b1;
                        state_next = ptlf_pkg::BK_MUL;
                    end
                    else
                    begin
                        idx_next   = '0;
                        rd_addr    = '0;
                        state_next = ptlf_pkg::BK_READ;
                    end
                end
                else if (rd_pg_reg == page_reg)
                begin
                    hit_next   = 1'b1;
                    frame_next = rd_fr_reg;
                    mv_pg_next = rd_pg_reg;
                    if (policy == ptlf_pkg::POLICY_LRU)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        rd_addr    = IW'(idx_reg + 1'b1);
                        state_next = ptlf_pkg::BK_SHIFT;
                    end
                    else
                        state_next = ptlf_pkg::BK_MUL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    rd_addr  = IW'(idx_reg + 1'b1);
                end
            end
            // eviction: entry 0 read, take its frame then shift
            ptlf_pkg::BK_READ:
            begin
                frame_next = rd_fr_reg;
                mv_pg_next = page_reg;
                idx_next   = NW'(1);
                rd_addr    = IW'(1);
                state_next = ptlf_pkg::BK_SHIFT;
            end
            // idx_reg points one past the slot being filled
            ptlf_pkg::BK_SHIFT:
            begin
                if (idx_reg == n_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = IW'(n_reg - 1'b1);
                    wr_pg      = mv_pg_reg;
                    wr_fr      = frame_reg;
                    state_next = ptlf_pkg::BK_MUL;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = IW'(idx_reg - 1'b1);
                    wr_pg    = rd_pg_reg;
                    wr_fr    = rd_fr_reg;
                    idx_next = idx_reg + 1'b1;
                    rd_addr  = IW'(idx_reg + 1'b1);
                end
            end
            ptlf_pkg::BK_MUL:
            begin
                occ_next   = n_reg;
                prod_next  = (ADDR_BITS+ptlf_pkg::PS_W)'(frame_reg) * ps_reg;
                state_next = ptlf_pkg::BK_OUT;
            end
            ptlf_pkg::BK_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ptlf_pkg::BK_IDLE;
            end
            default:
                state_next = ptlf_pkg::BK_IDLE;
        endcase
    end

    assign pa_trim = ptlf_pkg::PA_W'(pa_full);

    assign physical_address = pa_trim;
    assign frame_number     = ptlf_pkg::FN_W'(frame_reg);
    assign page_fault       = ~hit_reg;
endmodule

// File: design/page_table_translate_lru_fifo.sv
// page_table_translate_lru_fifo: top level of the page table translator
// depends on ptlf_pkg, ptlf_front, ptlf_fifo, ptlf_back
//
// Translates a virtual word address through a fully associative table of up to
// MAX_FRAMES mappings kept oldest to newest, with lru or fifo replacement. The
// front divides the address by the page size, one quotient bit per cycle; the
// back scans the table one entry a cycle from a memory with one read and one
// write port, then shifts entries one a cycle on a reorder, then multiplies
// frame by page size. Front and back overlap through a two-word queue, so the
// sustained rate is that of the slower of the two. A configuration write to the
// page size, frame count or policy register empties the table.
module page_table_translate_lru_fifo #(
    parameter int MAX_FRAMES = ptlf_pkg::MAX_FRAMES_DEF,
    parameter int ADDR_BITS  = ptlf_pkg::ADDR_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ptlf_pkg::IDX_W-1:0]     cfg_index,
    input  logic [ptlf_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ptlf_pkg::VA_W-1:0]      virtual_address,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ptlf_pkg::PA_W-1:0]      physical_address,
    output logic [ptlf_pkg::FN_W-1:0]      frame_number,
    output logic                           page_fault
);
    localparam int QW = 2 * ADDR_BITS + ptlf_pkg::PS_W;

    logic [ptlf_pkg::PS_W-1:0] page_words_reg;
    logic [ptlf_pkg::FC_W-1:0] frame_count_reg;
    logic                      policy_reg;
    logic                      clear;

    logic                      fq_valid, fq_ready, bq_valid, bq_ready;
    logic [ADDR_BITS-1:0]      f_page, f_off, b_page, b_off;
    logic [ptlf_pkg::PS_W-1:0] f_ps, b_ps;

    assign clear = cfg_we && (cfg_index == ptlf_pkg::REG_PAGE_SIZE
                              || cfg_index == ptlf_pkg::REG_FRAME_COUNT
                              || cfg_index == ptlf_pkg::REG_POLICY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_words_reg  <= ptlf_pkg::PS_W'(16);
            frame_count_reg <= ptlf_pkg::FC_W'(4);
            policy_reg      <= ptlf_pkg::POLICY_LRU;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ptlf_pkg::REG_PAGE_SIZE:   page_words_reg  <= cfg_data;
                ptlf_pkg::REG_FRAME_COUNT: frame_count_reg <= cfg_data[ptlf_pkg::FC_W-1:0];
                ptlf_pkg::REG_POLICY:      policy_reg      <= cfg_data[0];
                default:                   policy_reg      <= policy_reg;
            endcase
        end
    end

    ptlf_front #(.ADDR_BITS(ADDR_BITS)) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .virtual_address (virtual_address),
        .page_words      (page_words_reg),
        .q_valid         (fq_valid),
        .q_ready         (fq_ready),
        .q_page          (f_page),
        .q_offset        (f_off),
        .q_psize         (f_ps)
    );

    ptlf_fifo #(.W(QW)) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  ({f_page, f_off, f_ps}),
        .rd_valid (bq_valid),
        .rd_ready (bq_ready),
        .rd_data  ({b_page, b_off, b_ps})
    );

    ptlf_back #(.MAX_FRAMES(MAX_FRAMES), .ADDR_BITS(ADDR_BITS)) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (bq_valid),
        .q_ready          (bq_ready),
        .q_page           (b_page),
        .q_offset         (b_off),
        .q_psize          (b_ps),
        .frame_count      (frame_count_reg),
        .policy           (policy_reg),
        .clear            (clear),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .physical_address (physical_address),
        .frame_number     (frame_number),
        .page_fault       (page_fault)
    );
endmodule

// File: tb/page_table_translate_lru_fifo_tb.sv
// page_table_translate_lru_fifo_tb: self-checking testbench for the page table translator
// drives address words through a queue-fed driver, predicts each translation with its own
// table model and checks results in order; depends on ptlf_pkg and the top level
`timescale 1ns / 100ps

module page_table_translate_lru_fifo_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [ptlf_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [ptlf_pkg::PA_W-1:0] pa;
        logic [ptlf_pkg::FN_W-1:0] fn;
        logic                      fault;
    } xlate_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [ptlf_pkg::IDX_W-1:0]    cfg_index = ptlf_pkg::REG_PAGE_SIZE;
    logic [ptlf_pkg::CFG_W-1:0]    cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [ptlf_pkg::VA_W-1:0]     virtual_address = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [ptlf_pkg::PA_W-1:0]     physical_address;
    logic [ptlf_pkg::FN_W-1:0]     frame_number;
    logic                          page_fault;

    logic [ptlf_pkg::VA_W-1:0]     addr_queue[$];
    xlate_t              expected_xlate[$];
    int                  fail_count = 0;
    int                  idle_cycles = 0;
    bit                  no_idle = 1'b0;
    int                  hold_off = 0;

    // translator model state
    logic [16:0]         page_words_reg;
    logic [4:0]          frame_count_reg;
    logic                policy_reg;
    logic [19:0]         tbl_page[16];
    logic [3:0]          tbl_frame[16];
    int                  occupied;

    page_table_translate_lru_fifo i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .virtual_address(virtual_address),
        .out_valid(out_valid), .out_ready(out_ready),
        .physical_address(physical_address), .frame_number(frame_number),
        .page_fault(page_fault)
    );

    always #6 clk = ~clk;

    function automatic void table_reorder(int pos, int last);
        logic [19:0] pg;
        logic [3:0]  fr;
        pg = tbl_page[pos];
        fr = tbl_frame[pos];
        for (int k = pos; k < last; k++)
        begin
            tbl_page[k] = tbl_page[k+1];
            tbl_frame[k] = tbl_frame[k+1];
        end
        tbl_page[last] = pg;
        tbl_frame[last] = fr;
    endfunction

    function automatic xlate_t translate(logic [ptlf_pkg::VA_W-1:0] va);
        longint ps;
        int     fc, n, hit_at;
        logic [19:0] page;
        longint ofs;
        logic [3:0]  fr;
        xlate_t r;
        ps = (page_words_reg == 0) ? 1 : longint'(page_words_reg);
        fc = (frame_count_reg == 0) ? 1 : int'(frame_count_reg);
        if (fc > 16)
            fc = 16;
        n = (occupied > fc) ? fc : occupied;
        page = 20'(va / ps);
        ofs = va % ps;
        hit_at = -1;
        for (int i = 0; i < n; i++)
        begin
            if (hit_at < 0 && tbl_page[i] == page)
                hit_at = i;
        end
        if (hit_at >= 0)
        begin
            fr = tbl_frame[hit_at];
            if (policy_reg == ptlf_pkg::POLICY_LRU)
                table_reorder(hit_at, n - 1);
        end
        else if (n < fc)
        begin
            tbl_page[n] = page;
            tbl_frame[n] = 4'(n);
            fr = 4'(n);
            n++;
        end
        else
        begin
            tbl_page[0] = page;
            fr = tbl_frame[0];
            table_reorder(0, n - 1);
        end
        occupied = n;
        r.pa = ptlf_pkg::PA_W'(longint'(fr) * ps + ofs);
        r.fn = fr;
        r.fault = (hit_at < 0);
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready)
            begin
                if (addr_queue.size() > 0 && (no_idle || $urandom_range(99) >= 26))
                begin
                    virtual_address <= addr_queue[0];
                    expected_xlate.push_back(translate(addr_queue.pop_front()));
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver
    always @(posedge clk)
    begin
        xlate_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_xlate.size() == 0)
                begin
                    $error("unexpected word pa=%0h", physical_address);
                    fail_count++;
                end
                else
                begin
                    e = expected_xlate.pop_front();
                    if (physical_address !== e.pa)
                    begin
                        $error("physical_address exp %0h got %0h", e.pa, physical_address);
                        fail_count++;
                    end
                    if (frame_number !== e.fn)
                    begin
                        $error("frame_number exp %0d got %0d", e.fn, frame_number);
                        fail_count++;
                    end
                    if (page_fault !== e.fault)
                    begin
                        $error("page_fault exp %0b got %0b", e.fault, page_fault);
                        fail_count++;
                    end
                end
            end
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= no_idle || ($urandom_range(99) >= 26);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic write_reg(logic [ptlf_pkg::IDX_W-1:0] idx, logic [ptlf_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ptlf_pkg::REG_PAGE_SIZE:   page_words_reg = val;
            ptlf_pkg::REG_FRAME_COUNT: frame_count_reg = val[4:0];
            ptlf_pkg::REG_POLICY:      policy_reg = val[0];
            default:                   ;
        endcase
        if (idx <= ptlf_pkg::REG_POLICY)
            occupied = 0;
    endtask

    task automatic drain;
        while (addr_queue.size() > 0 || in_valid || expected_xlate.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // mostly addresses within a small working set so hits and evictions both occur
    function automatic logic [ptlf_pkg::VA_W-1:0] pick_addr(int ps, int pages);
        if ($urandom_range(9) == 0)
            return ptlf_pkg::VA_W'($urandom());
        return ptlf_pkg::VA_W'($urandom_range(pages - 1) * ps + $urandom_range(ps - 1));
    endfunction

    initial
    begin
        int ps_set[] = '{16, 1, 0, 65536, 100, 3, 4096, 131071};
        int fc_set[] = '{4, 1, 0, 16, 31, 2, 7, 16};
        int ps, fc, pages;
        page_words_reg = 16;
        frame_count_reg = 4;
        policy_reg = ptlf_pkg::POLICY_LRU;
        occupied = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, hits, fills, eviction under reset settings
        addr_queue = '{20'h0, 20'hFFFFF, 20'h00005, 20'h00010, 20'h00020, 20'h00030,
                       20'h00000, 20'h00040, 20'h00015, 20'h00050, 20'hFFFF0, 20'h00035,
                       20'h00045, 20'h55555, 20'hAAAAA};
        drain();
        write_reg(ptlf_pkg::REG_POLICY, ptlf_pkg::CFG_W'(ptlf_pkg::POLICY_FIFO));
        addr_queue = '{20'h0, 20'h10, 20'h20, 20'h30, 20'h0, 20'h40, 20'h0, 20'h10};
        drain();
        write_reg(REG_UNUSED, 17'h1FFFF);

        // long receiver hold-off while the sender keeps offering
        hold_off = 300;
        for (int i = 0; i < 20; i++)
            addr_queue.push_back(pick_addr(16, 8));
        drain();

        for (int ph = 0; ph < 16; ph++)
        begin
            ps = ps_set[ph % 8];
            fc = fc_set[(ph + ph / 8) % 8];
            write_reg(ptlf_pkg::REG_PAGE_SIZE, ptlf_pkg::CFG_W'(ps));
            write_reg(ptlf_pkg::REG_FRAME_COUNT, ptlf_pkg::CFG_W'(fc));
            write_reg(ptlf_pkg::REG_POLICY, ptlf_pkg::CFG_W'(ph[0]));
            no_idle = (ph == 5);
            pages = (fc == 0) ? 2 : ((fc > 16 ? 16 : fc) + 3);
            if (ps == 0)
                ps = 1;
            for (int i = 0; i < 40; i++)
                addr_queue.push_back(pick_addr(ps, pages));
            drain();
        end

        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// File: files.f
design/ptlf_pkg.sv
design/ptlf_front.sv
design/ptlf_fifo.sv
design/ptlf_back.sv
design/page_table_translate_lru_fifo.sv
tb/page_table_translate_lru_fifo_tb.sv
